@@ hw/rtl/ctc_pkg.sv @@
// Package for the token classifier: payload structs, token codes, character
// constants and the reserved-word tables used by the front end.
// No dependencies.
`default_nettype none

package ctc_pkg;

  localparam int NumKw     = 16;
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  typedef enum logic [2:0] {
    ClsReserved = 3'd0,
    ClsIdent    = 3'd1,
    ClsInteger  = 3'd2,
    ClsFloat    = 3'd3,
    ClsOperator = 3'd4
  } ctc_class_e;

  typedef enum logic [1:0] {
    KindLetter = 2'd0,
    KindUnder  = 2'd1,
    KindDigit  = 2'd2,
    KindOther  = 2'd3
  } ctc_kind_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } ctc_in_t;

  typedef struct packed {
    logic       has_token;
    logic [2:0] token_class;
    logic       ends_line;
    logic       is_final;
    logic       compile_error;
  } ctc_out_t;

  // Up to two results per accepted character; item0 goes first.
  typedef struct packed {
    logic [1:0] count;
    ctc_out_t   item0;
    ctc_out_t   item1;
  } ctc_push_t;

  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharUnder = 8'h5F;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharBang  = 8'h21;
  localparam logic [7:0] CharGt    = 8'h3E;
  localparam logic [7:0] CharLt    = 8'h3C;

  localparam logic [3:0] TokLenMax = 4'd15;

  // Reserved words, left-justified in 8 bytes and padded with zero bytes.
  localparam logic [63:0] KwText [NumKw] = '{
    {"const",   24'h0}, {"int",    40'h0}, {"float",  24'h0}, {"double", 16'h0},
    {"long",    32'h0}, {"static", 16'h0}, {"void",   32'h0}, {"char",   32'h0},
    {"extern",  16'h0}, {"return", 16'h0}, {"break",  24'h0}, {"enum",   32'h0},
    {"struct",  16'h0}, {"typedef", 8'h0}, {"union",  24'h0}, {"goto",   32'h0}
  };

  localparam logic [3:0] KwLen [NumKw] = '{
    4'd5, 4'd3, 4'd5, 4'd6, 4'd4, 4'd6, 4'd4, 4'd4,
    4'd6, 4'd6, 4'd5, 4'd4, 4'd6, 4'd7, 4'd5, 4'd4
  };

  // Words whose character at position pos exists and equals c.
  function automatic logic [NumKw-1:0] kw_hit(input logic [7:0] c, input logic [3:0] pos);
    logic [NumKw-1:0] hit;
    logic [63:0]      txt;
    hit = '0;
    for (int k = 0; k < NumKw; k++) begin
      txt    = KwText[k];
      hit[k] = !pos[3] && (pos < KwLen[k]) && (txt[63 - 8*pos[2:0] -: 8] == c);
    end
    return hit;
  endfunction

  // Words whose length equals len.
  function automatic logic [NumKw-1:0] kw_len_mask(input logic [3:0] len);
    logic [NumKw-1:0] m;
    m = '0;
    for (int k = 0; k < NumKw; k++) begin
      m[k] = (KwLen[k] == len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ctc_front.sv @@
// Front end of the token classifier: takes one character per cycle when accepted, tracks
// the pending token and pushes zero, one or two results. Uses ctc_pkg.
`default_nettype none

module ctc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  ctc_pkg::ctc_in_t in_data_i,
  output ctc_pkg::ctc_push_t push_o
);
  import ctc_pkg::*;

  logic             in_token_q, in_token_d;
  ctc_kind_e        kind_q, kind_d;
  logic [3:0]       len_q, len_d;
  logic [NumKw-1:0] alive_q, alive_d;
  logic             ident_ok_q, ident_ok_d;
  logic             number_ok_q, number_ok_d;
  logic [1:0]       dots_q, dots_d;
  logic [7:0]       op_a_q, op_a_d;
  logic [7:0]       op_b_q, op_b_d;
  logic             err_q, err_d;

  logic [7:0] c;
  logic       is_eoi, is_semi, is_space, is_term;
  logic       is_letter, is_digit;
  logic       op_ok, cls_ok;
  ctc_class_e cls;
  ctc_out_t   tok_item, stat_item;

  assign c         = in_data_i.char_code;
  assign is_eoi    = in_data_i.end_of_input;
  assign is_semi   = (c == CharSemi);
  assign is_space  = (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  assign is_term   = is_eoi || is_semi || is_space;
  assign is_letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  assign is_digit  = (c >= 8'h30) && (c <= 8'h39);

  always_comb begin
    op_ok = 1'b0;
    if (len_q == 4'd1) begin
      op_ok = (op_a_q == CharPlus) || (op_a_q == CharMinus) || (op_a_q == CharStar) ||
              (op_a_q == CharSlash) || (op_a_q == CharEq) || (op_a_q == CharGt) ||
              (op_a_q == CharLt);
    end else if (len_q == 4'd2) begin
      op_ok = (op_b_q == CharEq) &&
              ((op_a_q == CharEq) || (op_a_q == CharBang) || (op_a_q == CharGt) ||
               (op_a_q == CharLt));
    end
  end

  // Class of the pending token as it stands before this character.
  always_comb begin
    cls    = ClsIdent;
    cls_ok = 1'b0;
    case (kind_q)
      KindLetter: begin
        if (|(alive_q & kw_len_mask(len_q))) begin
          cls    = ClsReserved;
          cls_ok = 1'b1;
        end else begin
          cls_ok = ident_ok_q;
        end
      end
      KindUnder: cls_ok = ident_ok_q;
      KindDigit: begin
        cls    = (dots_q == 2'd0) ? ClsInteger : ClsFloat;
        cls_ok = number_ok_q && (dots_q != 2'd2);
      end
      default: begin
        cls    = ClsOperator;
        cls_ok = op_ok;
      end
    endcase
  end

  always_comb begin
    in_token_d  = in_token_q;
    kind_d      = kind_q;
    len_d       = len_q;
    alive_d     = alive_q;
    ident_ok_d  = ident_ok_q;
    number_ok_d = number_ok_q;
    dots_d      = dots_q;
    op_a_d      = op_a_q;
    op_b_d      = op_b_q;
    err_d       = err_q;
    push_o      = '0;

    if (accept_i && is_term) begin
      err_d = err_q | (in_token_q & ~cls_ok);
    end

    tok_item.has_token      = 1'b1;
    tok_item.token_class    = cls;
    tok_item.ends_line      = is_semi && !is_eoi;
    tok_item.is_final       = 1'b0;
    tok_item.compile_error  = err_d;
    stat_item.has_token     = 1'b0;
    stat_item.token_class   = ClsReserved;
    stat_item.ends_line     = !is_eoi;
    stat_item.is_final      = is_eoi;
    stat_item.compile_error = err_d;

    if (accept_i) begin
      if (is_term) begin
        // Every terminator leaves the token state cleared.
        in_token_d  = 1'b0;
        kind_d      = KindLetter;
        len_d       = '0;
        alive_d     = '1;
        ident_ok_d  = 1'b1;
        number_ok_d = 1'b1;
        dots_d      = '0;
        op_a_d      = '0;
        op_b_d      = '0;
        if (in_token_q && cls_ok) begin
          push_o.item0 = tok_item;
          if (is_eoi) begin
            push_o.item1 = stat_item;
            push_o.count = 2'd2;
          end else begin
            push_o.count = 2'd1;
          end
        end else if (is_eoi || is_semi) begin
          push_o.item0 = stat_item;
          push_o.count = 2'd1;
        end
      end else begin
        // State is already cleared between tokens, so position is len_q.
        in_token_d = 1'b1;
        if (!in_token_q) begin
          kind_d = is_letter ? KindLetter :
                   (c == CharUnder) ? KindUnder :
                   is_digit ? KindDigit : KindOther;
        end
        alive_d = alive_q & kw_hit(c, len_q);
        if (len_q == 4'd0) begin
          op_a_d = c;
        end else begin
          if (len_q == 4'd1) begin
            op_b_d = c;
          end
          if (!(is_letter || is_digit || (c == CharUnder))) begin
            ident_ok_d = 1'b0;
          end
          if (c == CharDot) begin
            if (dots_q != 2'd2) begin
              dots_d = dots_q + 2'd1;
            end
          end else if (!is_digit) begin
            number_ok_d = 1'b0;
          end
        end
        if (len_q != TokLenMax) begin
          len_d = len_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_token_q  <= 1'b0;
      kind_q      <= KindLetter;
      len_q       <= '0;
      alive_q     <= '1;
      ident_ok_q  <= 1'b1;
      number_ok_q <= 1'b1;
      dots_q      <= '0;
      op_a_q      <= '0;
      op_b_q      <= '0;
      err_q       <= 1'b0;
    end else begin
      in_token_q  <= in_token_d;
      kind_q      <= kind_d;
      len_q       <= len_d;
      alive_q     <= alive_d;
      ident_ok_q  <= ident_ok_d;
      number_ok_q <= number_ok_d;
      dots_q      <= dots_d;
      op_a_q      <= op_a_d;
      op_b_q      <= op_b_d;
      err_q       <= err_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ctc_fifo.sv @@
// Result queue between the front end and the output stage: takes up to two
// results per cycle and releases one per cycle when popped. Uses ctc_pkg.
`default_nettype none

module ctc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctc_pkg::ctc_push_t push_i,
  output logic               room_o,
  output logic               valid_o,
  output ctc_pkg::ctc_out_t  data_o,
  input  logic               pop_i
);
  import ctc_pkg::*;

  ctc_out_t        mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] wr_next;

  assign wr_next = wr_ptr_q + PtrW'(1);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  // Room for the largest burst one character can cause.
  assign room_o  = (cnt_q <= CntW'(FifoDepth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
    rd_ptr_d = rd_ptr_q + PtrW'(pop_i);
    cnt_d    = cnt_q + CntW'(push_i.count) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.item0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.item1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ctc_back.sv @@
// Output stage of the token classifier: registers the head of the result
// queue and presents it on the output channel. Uses ctc_pkg.
`default_nettype none

module ctc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  ctc_pkg::ctc_out_t q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  output ctc_pkg::ctc_out_t out_data_o,
  input  logic              out_stall_i
);
  import ctc_pkg::*;

  logic     valid_q, valid_d;
  ctc_out_t data_q;
  logic     load;

  // With a result queued, the register refills when it is empty or its transaction completes.
  assign load    = q_valid_i && (!valid_q || !out_stall_i);
  assign q_pop_o = load;
  assign valid_d = load || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= q_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

@@ hw/rtl/c_token_classifier.sv @@
// Token classifier top level: front end, result queue and output register.
// Results pass through a four-entry queue, then the output register.
// Throughput: one character per cycle while the queue has room; end of input
// with a pending token gives two results, drained one per unstalled cycle.
// Reset clears the token state, the sticky error flag and the queue.
// Depends on ctc_pkg, ctc_front, ctc_fifo and ctc_back.
`default_nettype none

module c_token_classifier (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  ctc_pkg::ctc_in_t  in_data_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output ctc_pkg::ctc_out_t out_data_o,
  input  logic              out_stall_i
);
  import ctc_pkg::*;

  ctc_push_t push;
  logic      room;
  logic      accept;
  logic      q_valid;
  ctc_out_t  q_data;
  logic      q_pop;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  ctc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push)
  );

  ctc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  ctc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

@@ tb/c_token_classifier_test.sv @@
// Self-checking testbench for c_token_classifier: feeds a character stream,
// predicts the token results in step and compares every result transaction.
// Depends on ctc_pkg and the c_token_classifier RTL.
module c_token_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ctc_pkg::*;

  localparam int RandomChars = 1300;
  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 20;
  localparam int CalmFrom    = 600;
  localparam int CalmTo      = 1100;
  localparam int HoldCycles  = 64;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  ctc_in_t  in_data_i   = '0;
  logic     in_stall_o;
  logic     out_valid_o;
  ctc_out_t out_data_o;
  logic     out_stall_i = 1'b0;

  c_token_classifier u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  string reserved_words [16] = '{
    "const", "int", "float", "double", "long", "static", "void", "char",
    "extern", "return", "break", "enum", "struct", "typedef", "union", "goto"
  };
  string op_spellings [11] = '{"+", "-", "*", "/", "=", "==", "!=", ">=", "<=", ">", "<"};
  // Letters occupy 0..51, digits 52..61 and the underscore 62.
  string ident_alphabet = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  string op_alphabet    = "+-*/=!<>.";

  ctc_in_t  char_stream [$];
  ctc_out_t results_due [$];

  int unsigned cyc            = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;

  wire calm = (cyc >= CalmFrom) && (cyc < CalmTo);

  // Token state of the prediction.
  logic       tok_open;
  ctc_kind_e  lead_kind;
  logic [3:0] tok_len;
  logic [15:0] words_alive;
  logic       ident_clean;
  logic       number_clean;
  logic [1:0] dots;
  logic [7:0] op_char0;
  logic [7:0] op_char1;
  logic       error_flag;

  initial begin
    forever #5ns clk_i = ~clk_i;
  end

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CharSpace || (c >= CharTab && c <= CharCr);
  endfunction

  task automatic drop_token();
    tok_open     = 1'b0;
    lead_kind    = KindLetter;
    tok_len      = '0;
    words_alive  = '1;
    ident_clean  = 1'b1;
    number_clean = 1'b1;
    dots         = '0;
    op_char0     = '0;
    op_char1     = '0;
  endtask

  function automatic bit op_known();
    if (tok_len == 4'd1) begin
      return op_char0 == CharPlus || op_char0 == CharMinus || op_char0 == CharStar ||
             op_char0 == CharSlash || op_char0 == CharEq || op_char0 == CharGt ||
             op_char0 == CharLt;
    end
    if (tok_len == 4'd2) begin
      return op_char1 == CharEq && (op_char0 == CharEq || op_char0 == CharBang ||
                                    op_char0 == CharGt || op_char0 == CharLt);
    end
    return 1'b0;
  endfunction

  // Class code of the pending token, or -1 when it is malformed.
  function automatic int pending_class();
    case (lead_kind)
      KindLetter: begin
        for (int k = 0; k < 16; k++) begin
          if (words_alive[k] && reserved_words[k].len() == tok_len) return ClsReserved;
        end
        return ident_clean ? ClsIdent : -1;
      end
      KindUnder: return ident_clean ? ClsIdent : -1;
      KindDigit: begin
        if (!number_clean || dots == 2'd2) return -1;
        return (dots == 2'd0) ? ClsInteger : ClsFloat;
      end
      default: return op_known() ? ClsOperator : -1;
    endcase
  endfunction

  task automatic close_token(output int cls);
    cls = pending_class();
    if (cls < 0) error_flag = 1'b1;
    drop_token();
  endtask

  task automatic queue_token_result(bit has, int cls, bit eol, bit fin);
    ctc_out_t r;
    r.has_token     = has;
    r.token_class   = ctc_class_e'(cls);
    r.ends_line     = eol;
    r.is_final      = fin;
    r.compile_error = error_flag;
    results_due.push_back(r);
  endtask

  task automatic extend_token(logic [7:0] c);
    string w;
    if (!tok_open) begin
      drop_token();
      tok_open  = 1'b1;
      lead_kind = is_alpha(c) ? KindLetter : (c == CharUnder) ? KindUnder :
                  is_num(c) ? KindDigit : KindOther;
    end
    for (int k = 0; k < 16; k++) begin
      w = reserved_words[k];
      if (tok_len >= w.len() || w[tok_len] != c) words_alive[k] = 1'b0;
    end
    if (tok_len == 4'd0) begin
      op_char0 = c;
    end else begin
      if (tok_len == 4'd1) op_char1 = c;
      if (!(is_alpha(c) || is_num(c) || c == CharUnder)) ident_clean = 1'b0;
      if (c == CharDot) begin
        if (dots != 2'd2) dots++;
      end else if (!is_num(c)) begin
        number_clean = 1'b0;
      end
    end
    if (tok_len != TokLenMax) tok_len++;
  endtask

  task automatic predict_char(ctc_in_t it);
    int cls;
    cls = -1;
    if (it.end_of_input) begin
      if (tok_open) begin
        close_token(cls);
        if (cls >= 0) queue_token_result(1'b1, cls, 1'b0, 1'b0);
      end
      drop_token();
      queue_token_result(1'b0, ClsReserved, 1'b0, 1'b1);
    end else if (it.char_code == CharSemi) begin
      if (tok_open) close_token(cls);
      if (cls >= 0) queue_token_result(1'b1, cls, 1'b1, 1'b0);
      else queue_token_result(1'b0, ClsReserved, 1'b1, 1'b0);
    end else if (is_blank(it.char_code)) begin
      if (tok_open) begin
        close_token(cls);
        if (cls >= 0) queue_token_result(1'b1, cls, 1'b0, 1'b0);
      end
    end else begin
      extend_token(it.char_code);
    end
  endtask

  // Stimulus construction.
  task automatic add_char_item(logic [7:0] c);
    ctc_in_t it;
    it.char_code    = c;
    it.end_of_input = 1'b0;
    char_stream.push_back(it);
  endtask

  task automatic add_eoi_item();
    ctc_in_t it;
    it.char_code    = 8'($urandom);
    it.end_of_input = 1'b1;
    char_stream.push_back(it);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char_item(s[i]);
  endtask

  task automatic add_random_token();
    string w;
    int    n;
    case ($urandom_range(0, 9))
      0, 1: add_text(reserved_words[$urandom_range(0, 15)]);
      2: begin
        // Near misses of a reserved word: a proper prefix or one extra character.
        w = reserved_words[$urandom_range(0, 15)];
        if ($urandom_range(0, 1)) begin
          add_text(w.substr(0, $urandom_range(0, w.len() - 2)));
        end else begin
          add_text(w);
          add_char_item(ident_alphabet[$urandom_range(0, 62)]);
        end
      end
      3, 4: begin
        add_char_item(($urandom_range(0, 4) == 0) ? CharUnder
                                                  : ident_alphabet[$urandom_range(0, 51)]);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 6);
        repeat (n) add_char_item(ident_alphabet[$urandom_range(0, 62)]);
      end
      5: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 4);
        repeat (n) add_char_item(ident_alphabet[$urandom_range(52, 61)]);
      end
      6: begin
        repeat ($urandom_range(1, 3)) add_char_item(ident_alphabet[$urandom_range(52, 61)]);
        add_char_item(CharDot);
        repeat ($urandom_range(0, 3)) add_char_item(ident_alphabet[$urandom_range(52, 61)]);
        if ($urandom_range(0, 3) == 0) add_char_item(CharDot);
      end
      7: add_text(op_spellings[$urandom_range(0, 10)]);
      8: repeat ($urandom_range(1, 3)) add_char_item(op_alphabet[$urandom_range(0, 8)]);
      default: begin
        // A plausible lead with an arbitrary byte as its second character.
        add_char_item(ident_alphabet[$urandom_range(0, 62)]);
        add_char_item(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) add_char_item(ident_alphabet[$urandom_range(0, 62)]);
      end
    endcase
  endtask

  task automatic add_separator();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick >= 96) begin
      add_eoi_item();
    end else if (pick >= 85) begin
      // No separator: neighboring tokens run together.
    end else if (pick >= 55) begin
      if ($urandom_range(0, 3) == 0) add_char_item(CharSpace);
      repeat ($urandom_range(1, 3)) add_char_item(CharSemi);
    end else begin
      repeat ($urandom_range(1, 2)) begin
        add_char_item(($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13)) : CharSpace);
      end
    end
  endtask

  // Sender: offers the next pending character unless it idles this cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_char(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (char_stream.size() != 0 && (calm || $urandom_range(0, 99) >= 27)) begin
          in_data_i  <= char_stream.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Receiver: checks each result transaction and stalls at random, with one
  // long hold-off so the internal queue fills and the input side backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    ctc_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (results_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: expected no result, got %p", $time, out_data_o);
        end else begin
          want = results_due.pop_front();
          check_field("has_token", want.has_token, out_data_o.has_token);
          check_field("token_class", want.token_class, out_data_o.token_class);
          check_field("ends_line", want.ends_line, out_data_o.ends_line);
          check_field("is_final", want.is_final, out_data_o.is_final);
          check_field("compile_error", want.compile_error, out_data_o.compile_error);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && results_seen >= 60) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 27);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("c_token_classifier verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int directed_len;
    drop_token();
    error_flag = 1'b0;

    // Every token class, a double ';', a malformed identifier, high and zero
    // bytes, and end of input both with and without a pending token.
    add_text("goto _a 7 1.5 <=;;a$ ");
    add_char_item(8'hFF);
    add_char_item(8'h00);
    add_eoi_item();
    add_text("z");
    add_eoi_item();
    add_eoi_item();
    directed_len = char_stream.size();

    while (char_stream.size() < directed_len + RandomChars) begin
      add_random_token();
      add_separator();
    end
    add_eoi_item();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (char_stream.size() != 0 || in_valid_i || results_due.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("c_token_classifier verification clean");
    end else begin
      $display("c_token_classifier verification failed");
    end
    $finish;
  end

endmodule
